>>> sv/m2q_pkg.sv
// ============================================================================
// m2q_pkg
// Shared types and constants for the matrix-to-quaternion pipeline.
// ============================================================================
package m2q_pkg;

  // Width of one scaled magnitude, and of the squared-sum accumulator
  localparam int unsigned MG_W       = 31;
  localparam int unsigned ACC_W      = 64;
  // One root bit per cell over the 64-bit sum
  localparam int unsigned ROOT_STEPS = 32;

  // Per-item flags carried down the chain
  typedef struct packed {
    logic       degen;
    logic [3:0] neg;
  } flags_t;

  // Side data riding along the square-root cells
  typedef struct packed {
    flags_t                     flags;
    logic [3:0][MG_W-1:0]       mg;
  } side_t;

endpackage

>>> sv/m2q_sqrt_cell.sv
// ============================================================================
// m2q_sqrt_cell
// One digit step of the integer square root; holds remainder, partial root
// and side data for one item and hands them to the next cell.
// ============================================================================
module m2q_sqrt_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [m2q_pkg::ACC_W-1:0]  n_i,
  input  logic [m2q_pkg::ACC_W-1:0]  res_i,
  input  m2q_pkg::side_t             side_i,
  output logic [m2q_pkg::ACC_W-1:0]  n_o,
  output logic [m2q_pkg::ACC_W-1:0]  res_o,
  output m2q_pkg::side_t             side_o
);

  localparam logic [m2q_pkg::ACC_W-1:0] BIT = m2q_pkg::ACC_W'(1) << (62 - 2 * STEP);

  logic [m2q_pkg::ACC_W-1:0] trial;
  logic [m2q_pkg::ACC_W-1:0] n_d, res_d;
  logic [m2q_pkg::ACC_W-1:0] n_q, res_q;
  m2q_pkg::side_t            side_q;

  // Trial subtract for this root bit
  always_comb begin
    trial = res_i + BIT;
    if (n_i >= trial) begin
      n_d   = n_i - trial;
      res_d = (res_i >> 1) + BIT;
    end else begin
      n_d   = n_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q    <= n_d;
      res_q  <= res_d;
      side_q <= side_i;
    end
  end

  assign n_o    = n_q;
  assign res_o  = res_q;
  assign side_o = side_q;

endmodule

>>> sv/m2q_div_cell.sv
// ============================================================================
// m2q_div_cell
// One quotient bit of a restoring division for one quaternion lane.
// ============================================================================
module m2q_div_cell #(
  parameter int unsigned NW    = 46,
  parameter int unsigned QW    = 15,
  parameter int unsigned SHIFT = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] n_i,
  input  logic [31:0]   d_i,
  input  logic [QW-1:0] q_i,
  output logic [NW-1:0] n_o,
  output logic [31:0]   d_o,
  output logic [QW-1:0] q_o
);

  logic [NW-1:0] dsh;
  logic [NW-1:0] n_d, n_q;
  logic [QW-1:0] q_d, q_q;
  logic [31:0]   d_q;

  // Compare against the shifted divisor, subtract on success
  always_comb begin
    dsh = NW'(d_i) << SHIFT;
    if (n_i >= dsh) begin
      n_d = n_i - dsh;
      q_d = q_i | (QW'(1) << SHIFT);
    end else begin
      n_d = n_i;
      q_d = q_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q <= n_d;
      q_q <= q_d;
      d_q <= d_i;
    end
  end

  assign n_o = n_q;
  assign q_o = q_q;
  assign d_o = d_q;

endmodule

>>> sv/matrix_to_quaternion.sv
// Throughput: one matrix per cycle; the chain of root and divider cells moves
// every cycle unless the two-entry output buffer is full.
// Reset: asynchronous, active low; clears stage valid bits and output buffer,
// datapath registers are not reset.
// ============================================================================
// matrix_to_quaternion
// Rotation matrix (Q2.14) to normalized unit quaternion, Shepperd branches,
// pipelined as a chain of square-root cells and divider cells.
// ============================================================================
module matrix_to_quaternion #(
  parameter int unsigned FRAC_BITS  = 14,
  parameter int unsigned DATA_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         stall_o,
  input  logic signed [DATA_WIDTH-1:0] m11_i,
  input  logic signed [DATA_WIDTH-1:0] m12_i,
  input  logic signed [DATA_WIDTH-1:0] m13_i,
  input  logic signed [DATA_WIDTH-1:0] m21_i,
  input  logic signed [DATA_WIDTH-1:0] m22_i,
  input  logic signed [DATA_WIDTH-1:0] m23_i,
  input  logic signed [DATA_WIDTH-1:0] m31_i,
  input  logic signed [DATA_WIDTH-1:0] m32_i,
  input  logic signed [DATA_WIDTH-1:0] m33_i,
  output logic                         valid_o,
  input  logic                         stall_i,
  output logic signed [DATA_WIDTH-1:0] quat_w_o,
  output logic signed [DATA_WIDTH-1:0] quat_x_o,
  output logic signed [DATA_WIDTH-1:0] quat_y_o,
  output logic signed [DATA_WIDTH-1:0] quat_z_o,
  output logic                         degenerate_o
);

  localparam int unsigned BW    = (DATA_WIDTH > FRAC_BITS + 1) ? DATA_WIDTH : FRAC_BITS + 1;
  localparam int unsigned UW    = BW + 3;
  localparam int unsigned MAXSH = (UW > 31) ? UW - 31 : 0;
  localparam int unsigned SHW   = $clog2(MAXSH + 2);
  localparam int unsigned QW    = FRAC_BITS + 1;
  localparam int unsigned NW    = FRAC_BITS + 32;
  localparam int unsigned NSTG  = 38 + QW;
  localparam int unsigned PW    = ((QW > DATA_WIDTH) ? QW : DATA_WIDTH) + 1;
  localparam int unsigned MGW   = m2q_pkg::MG_W;
  localparam int unsigned AW    = m2q_pkg::ACC_W;
  localparam int unsigned RS    = m2q_pkg::ROOT_STEPS;

  localparam logic signed [UW-1:0] ONE_U = UW'(1) << FRAC_BITS;
  localparam logic [PW-1:0] QMAX_P = (PW'(1) << (DATA_WIDTH - 1)) - PW'(1);
  localparam logic [PW-1:0] HALF_P = PW'(1) << (DATA_WIDTH - 1);
  localparam logic signed [DATA_WIDTH-1:0] QMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] QMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [DATA_WIDTH-1:0] ONE_SAT =
    (FRAC_BITS >= DATA_WIDTH - 1) ? QMAX : DATA_WIDTH'(1) << FRAC_BITS;

  typedef enum logic [1:0] {
    DOM_X = 2'd0,
    DOM_Y = 2'd1,
    DOM_Z = 2'd2
  } dom_e;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] w;
    logic signed [DATA_WIDTH-1:0] x;
    logic signed [DATA_WIDTH-1:0] y;
    logic signed [DATA_WIDTH-1:0] z;
    logic                         degen;
  } res_t;

  // --------------------------------------------------------------------------
  // Pipeline control: all stages advance together unless the spare is full
  // --------------------------------------------------------------------------
  logic            en;
  logic [NSTG-1:0] vld_q;
  logic            spare_v_q, out_v_q;
  res_t            out_q, spare_q, res_d;

  assign en      = !spare_v_q;
  assign stall_o = spare_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], valid_i};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: input register
  // --------------------------------------------------------------------------
  logic signed [DATA_WIDTH-1:0] a_q [9];

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q[0] <= m11_i;
      a_q[1] <= m12_i;
      a_q[2] <= m13_i;
      a_q[3] <= m21_i;
      a_q[4] <= m22_i;
      a_q[5] <= m23_i;
      a_q[6] <= m31_i;
      a_q[7] <= m32_i;
      a_q[8] <= m33_i;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: branch select and unnormalized quaternion
  // --------------------------------------------------------------------------
  logic signed [UW-1:0] ext [9];
  logic signed [UW-1:0] tr, diag_ab;
  logic signed [UW-1:0] u_d [4];
  logic signed [UW-1:0] u_q [4];
  logic                 dg1_d, dg1_q;
  dom_e                 dom_ab, dom;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      ext[i] = UW'(a_q[i]);
    end
    tr      = ONE_U + ext[0] + ext[4] + ext[8];
    dom_ab  = (ext[0] > ext[4]) ? DOM_X : DOM_Y;
    diag_ab = (ext[0] > ext[4]) ? ext[0] : ext[4];
    dom     = (diag_ab > ext[8]) ? dom_ab : DOM_Z;
    dg1_d   = 1'b0;
    if (tr > ONE_U) begin
      u_d[0] = tr;
      u_d[1] = ext[7] - ext[5];
      u_d[2] = ext[2] - ext[6];
      u_d[3] = ext[3] - ext[1];
    end else begin
      unique case (dom)
        DOM_X: begin
          u_d[1] = ONE_U + ext[0] - ext[4] - ext[8];
          u_d[2] = ext[3] + ext[1];
          u_d[3] = ext[2] + ext[6];
          u_d[0] = ext[7] - ext[5];
          dg1_d  = (u_d[1] <= 0);
        end
        DOM_Y: begin
          u_d[2] = ONE_U - ext[0] + ext[4] - ext[8];
          u_d[1] = ext[3] + ext[1];
          u_d[3] = ext[7] + ext[5];
          u_d[0] = ext[2] - ext[6];
          dg1_d  = (u_d[2] <= 0);
        end
        DOM_Z: begin
          u_d[3] = ONE_U - ext[0] - ext[4] + ext[8];
          u_d[1] = ext[2] + ext[6];
          u_d[2] = ext[7] + ext[5];
          u_d[0] = ext[3] - ext[1];
          dg1_d  = (u_d[3] <= 0);
        end
        default: begin
          for (int k = 0; k < 4; k++) begin
            u_d[k] = '0;
          end
          dg1_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q   <= u_d;
      dg1_q <= dg1_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: magnitudes, scale down below 2^31
  // --------------------------------------------------------------------------
  logic [UW-1:0]    mabs [4];
  logic [UW-1:0]    mx;
  logic [SHW-1:0]   sh;
  logic [UW+30:0]   wide [4];
  logic [3:0]       neg_d;
  m2q_pkg::side_t   s2_q;

  always_comb begin
    mx = '0;
    for (int k = 0; k < 4; k++) begin
      neg_d[k] = u_q[k][UW-1];
      mabs[k]  = neg_d[k] ? UW'(-u_q[k]) : UW'(u_q[k]);
      if (mabs[k] > mx) begin
        mx = mabs[k];
      end
    end
    sh = '0;
    for (int s = MAXSH; s >= 0; s--) begin
      if ((64'(mx) >> s) < 64'd2147483648) begin
        sh = SHW'(s);
      end
    end
    for (int k = 0; k < 4; k++) begin
      wide[k] = {31'd0, mabs[k]} >> sh;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q.flags.degen <= dg1_q;
      s2_q.flags.neg   <= neg_d;
      for (int k = 0; k < 4; k++) begin
        s2_q.mg[k] <= wide[k][MGW-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: squares; stage 4: sum of squares
  // --------------------------------------------------------------------------
  logic [2*MGW-1:0] sq_q [4];
  m2q_pkg::side_t   s3_q, s4_q;
  logic [AW-1:0]    sum_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        sq_q[k] <= s2_q.mg[k] * s2_q.mg[k];
      end
      s3_q  <= s2_q;
      sum_q <= AW'(sq_q[0]) + AW'(sq_q[1]) + AW'(sq_q[2]) + AW'(sq_q[3]);
      s4_q  <= s3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Square-root cell chain, one root bit per cell
  // --------------------------------------------------------------------------
  logic [AW-1:0]  rn   [RS+1];
  logic [AW-1:0]  rres [RS+1];
  m2q_pkg::side_t rsd  [RS+1];

  assign rn[0]   = sum_q;
  assign rres[0] = '0;
  assign rsd[0]  = s4_q;

  for (genvar g = 0; g < RS; g++) begin : g_root
    m2q_sqrt_cell #(
      .STEP (g)
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .n_i    (rn[g]),
      .res_i  (rres[g]),
      .side_i (rsd[g]),
      .n_o    (rn[g+1]),
      .res_o  (rres[g+1]),
      .side_o (rsd[g+1])
    );
  end

  // --------------------------------------------------------------------------
  // Divider setup: numerator mg*ONE + mag/2, zero-magnitude guard
  // --------------------------------------------------------------------------
  logic [31:0]     mag;
  logic [NW-1:0]   dn [4][QW+1];
  logic [31:0]     dd [4][QW+1];
  logic [QW-1:0]   dq [4][QW+1];
  logic [NW-1:0]   n0_q [4];
  logic [31:0]     d0_q;
  m2q_pkg::flags_t flg_q [QW+1];

  assign mag = rres[RS][31:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        n0_q[k] <= (NW'(rsd[RS].mg[k]) << FRAC_BITS) + NW'(mag >> 1);
      end
      d0_q           <= mag;
      flg_q[0].neg   <= rsd[RS].flags.neg;
      flg_q[0].degen <= rsd[RS].flags.degen | (mag == 32'd0);
      for (int j = 1; j <= QW; j++) begin
        flg_q[j] <= flg_q[j-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Divider cell chains, one quotient bit per cell and lane
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < 4; k++) begin : g_lane
    assign dn[k][0] = n0_q[k];
    assign dd[k][0] = d0_q;
    assign dq[k][0] = '0;
    for (genvar j = 0; j < QW; j++) begin : g_bit
      m2q_div_cell #(
        .NW    (NW),
        .QW    (QW),
        .SHIFT (QW - 1 - j)
      ) u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .n_i   (dn[k][j]),
        .d_i   (dd[k][j]),
        .q_i   (dq[k][j]),
        .n_o   (dn[k][j+1]),
        .d_o   (dd[k][j+1]),
        .q_o   (dq[k][j+1])
      );
    end
  end

  // --------------------------------------------------------------------------
  // Sign, saturation and identity substitution
  // --------------------------------------------------------------------------
  logic [PW-1:0]                qv [4];
  logic signed [DATA_WIDTH-1:0] qs [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      qv[k] = PW'(dq[k][QW]);
      if (flg_q[QW].neg[k]) begin
        qs[k] = (qv[k] > HALF_P) ? QMIN : DATA_WIDTH'(PW'(0) - qv[k]);
      end else begin
        qs[k] = (qv[k] > QMAX_P) ? QMAX : DATA_WIDTH'(qv[k]);
      end
    end
    if (flg_q[QW].degen) begin
      res_d = '{w: ONE_SAT, x: '0, y: '0, z: '0, degen: 1'b1};
    end else begin
      res_d = '{w: qs[0], x: qs[1], y: qs[2], z: qs[3], degen: 1'b0};
    end
  end

  // --------------------------------------------------------------------------
  // Output register with one spare entry
  // --------------------------------------------------------------------------
  logic out_take, pipe_v;

  assign out_take = out_v_q && !stall_i;
  assign pipe_v   = vld_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q   <= 1'b0;
      spare_v_q <= 1'b0;
    end else if (spare_v_q) begin
      if (out_take) begin
        spare_v_q <= 1'b0;
      end
    end else if (pipe_v) begin
      if (out_v_q && !out_take) begin
        spare_v_q <= 1'b1;
      end
      out_v_q <= 1'b1;
    end else if (out_take) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (spare_v_q) begin
      if (out_take) begin
        out_q <= spare_q;
      end
    end else if (pipe_v) begin
      if (out_v_q && !out_take) begin
        spare_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign valid_o      = out_v_q;
  assign quat_w_o     = out_q.w;
  assign quat_x_o     = out_q.x;
  assign quat_y_o     = out_q.y;
  assign quat_z_o     = out_q.z;
  assign degenerate_o = out_q.degen;

`ifndef ASSERT_OFF
  // Spare entry is only used behind a held output
  a_spare_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    spare_v_q |-> out_v_q)
    else $error("spare entry valid without output entry");

  // Degenerate results carry the identity
  a_degen_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && degenerate_o) |-> (quat_x_o == '0 && quat_y_o == '0 && quat_z_o == '0
                                   && quat_w_o == ONE_SAT))
    else $error("degenerate result is not the identity");

  // Input stall only starts after an output stall
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(stall_o) |-> $past(valid_o && stall_i))
    else $error("input stall without output back-pressure");
`endif

endmodule
